// ===== hdl/umpq_pkg.sv =====
// Shared types and constants for the unordered max priority queue.
// Used by every module of the block; depends on nothing else.

package umpq_pkg;

	localparam int DEPTH = 128;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Operation codes.
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_FIN   = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

endpackage

// ===== hdl/umpq_store.sv =====
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on umpq_pkg for the depth and the entry type.

module umpq_store (
	input  logic                             clk,
	input  logic                             we,
	input  logic [umpq_pkg::IDX_W-1:0]       waddr,
	input  umpq_pkg::entry_t                 wdata,
	input  logic [umpq_pkg::IDX_W-1:0]       raddr,
	output umpq_pkg::entry_t                 rdata
);

	umpq_pkg::entry_t mem_q [umpq_pkg::DEPTH];
	umpq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/umpq_cmp.sv =====
// Shared compare unit: decides whether a candidate entry beats the current best.
// Depends on umpq_pkg for the entry type.

module umpq_cmp (
	input  umpq_pkg::entry_t cand,
	input  umpq_pkg::entry_t best,
	output logic             better
);

	// Higher priority wins; on a tie the larger value wins. Full ties keep
	// the earlier entry, so strict comparisons are used.
	always_comb begin
		better = (cand.prio > best.prio) ||
			((cand.prio == best.prio) && (cand.value > best.value));
	end

endmodule

// ===== hdl/unordered_max_priority_queue.sv =====
// Top level of the unordered max priority queue: sequencer, result registers.
// Depends on umpq_pkg, umpq_store and umpq_cmp.
//
// Usage: a command transfer happens at a rising edge with start high and busy
// low; op, item_value and item_priority are sampled then. Every command gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it and must take it in that cycle.
// Enqueue, an unused op code, and peek or dequeue on an empty queue finish at
// once: done rises the cycle after the transfer and busy stays low.
// Peek with N stored entries scans them one per cycle through the single
// memory read port and the shared compare unit.
// Dequeue adds a shift of the entries behind the chosen one, one entry per
// cycle over the same read port plus the write port, and one final write;
// removing the last entry needs no shift and finishes like a peek.
// busy is high from the cycle after the transfer until the result shows.
// Reset empties the queue; memory contents are not cleared and never need to
// be, since only data from positions below the fill count is ever used.

module unordered_max_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic signed [31:0]               item_value,
	input  logic signed [31:0]               item_priority,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [31:0]               out_value,
	output logic signed [31:0]               out_priority,
	output logic [6:0]                       out_position,
	output logic [7:0]                       occupancy
);

	localparam int IW = umpq_pkg::IDX_W;
	localparam int CW = umpq_pkg::CNT_W;

	umpq_pkg::state_t state_q;
	logic [CW-1:0]    count_q;
	logic             deq_q;
	logic             first_q;
	logic [IW-1:0]    scan_idx_q;
	logic [IW-1:0]    rd_pos_q;
	logic [IW-1:0]    best_pos_q;
	umpq_pkg::entry_t best_q;
	logic [IW-1:0]    sh_rd_q;
	logic [IW-1:0]    wr_addr_q;
	logic             wr_pend_q;

	logic             done_q;
	logic [1:0]       status_q;
	logic signed [31:0] value_q;
	logic signed [31:0] priority_q;
	logic [6:0]       position_q;
	logic [7:0]       occupancy_q;

	logic             accept;
	logic             full;
	logic [IW-1:0]    last_idx;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	umpq_pkg::entry_t mem_wdata;
	logic [IW-1:0]    mem_raddr;
	umpq_pkg::entry_t mem_rdata;
	umpq_pkg::entry_t item;
	logic             better;

	assign accept   = start && !busy;
	assign full     = (count_q == CW'(umpq_pkg::DEPTH));
	assign last_idx = IW'(count_q - CW'(1));
	assign item     = '{value: item_value, prio: item_priority};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		case (state_q)
			umpq_pkg::S_IDLE: begin
				mem_we    = accept && (op == umpq_pkg::OP_ENQ) && !full;
				mem_waddr = count_q[IW-1:0];
				mem_wdata = item;
			end
			umpq_pkg::S_SCAN: begin
				mem_raddr = scan_idx_q;
			end
			umpq_pkg::S_SHIFT: begin
				mem_raddr = sh_rd_q;
				mem_we    = wr_pend_q;
			end
			umpq_pkg::S_DRAIN: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	umpq_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	umpq_cmp u_cmp (
		.cand   (mem_rdata),
		.best   (best_q),
		.better (better)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= umpq_pkg::S_IDLE;
			count_q    <= '0;
			done_q     <= 1'b0;
			first_q    <= 1'b0;
			wr_pend_q  <= 1'b0;
			deq_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				umpq_pkg::S_IDLE: begin
					if (accept) begin
						deq_q <= (op == umpq_pkg::OP_DEQ);
						if ((op == umpq_pkg::OP_DEQ || op == umpq_pkg::OP_PEEK) &&
							(count_q != '0)) begin
							state_q <= umpq_pkg::S_SCAN;
							first_q <= 1'b1;
						end else begin
							done_q <= 1'b1;
							if ((op == umpq_pkg::OP_ENQ) && !full) begin
								count_q <= count_q + CW'(1);
							end
						end
					end
				end
				umpq_pkg::S_SCAN: begin
					first_q <= 1'b0;
					if (rd_pos_q == last_idx) begin
						state_q <= umpq_pkg::S_FIN;
					end
				end
				umpq_pkg::S_FIN: begin
					if (!deq_q) begin
						done_q  <= 1'b1;
						state_q <= umpq_pkg::S_IDLE;
					end else if (best_pos_q == last_idx) begin
						done_q  <= 1'b1;
						count_q <= count_q - CW'(1);
						state_q <= umpq_pkg::S_IDLE;
					end else begin
						wr_pend_q <= 1'b0;
						state_q   <= umpq_pkg::S_SHIFT;
					end
				end
				umpq_pkg::S_SHIFT: begin
					wr_pend_q <= 1'b1;
					if (sh_rd_q == last_idx) begin
						state_q <= umpq_pkg::S_DRAIN;
					end
				end
				umpq_pkg::S_DRAIN: begin
					done_q  <= 1'b1;
					count_q <= count_q - CW'(1);
					state_q <= umpq_pkg::S_IDLE;
				end
				default: begin
					state_q <= umpq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: scan pointers, best entry, shift pointers, result.
	always_ff @(posedge clk) begin
		case (state_q)
			umpq_pkg::S_IDLE: begin
				scan_idx_q <= IW'(1);
				rd_pos_q   <= '0;
				if (accept) begin
					value_q     <= '0;
					priority_q  <= '0;
					position_q  <= '0;
					occupancy_q <= 8'(count_q);
					status_q    <= umpq_pkg::ST_OK;
					if (op == umpq_pkg::OP_ENQ) begin
						if (full) begin
							status_q <= umpq_pkg::ST_FULL;
						end else begin
							occupancy_q <= 8'(count_q + CW'(1));
						end
					end else if ((op == umpq_pkg::OP_DEQ || op == umpq_pkg::OP_PEEK) &&
						(count_q == '0)) begin
						status_q <= umpq_pkg::ST_EMPTY;
					end
				end
			end
			umpq_pkg::S_SCAN: begin
				// The memory data belongs to the address issued in the previous cycle.
				if (first_q || better) begin
					best_q     <= mem_rdata;
					best_pos_q <= rd_pos_q;
				end
				rd_pos_q   <= scan_idx_q;
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			umpq_pkg::S_FIN: begin
				sh_rd_q     <= best_pos_q + IW'(1);
				status_q    <= umpq_pkg::ST_OK;
				value_q     <= best_q.value;
				priority_q  <= best_q.prio;
				position_q  <= 7'(best_pos_q);
				occupancy_q <= deq_q ? 8'(count_q - CW'(1)) : 8'(count_q);
			end
			umpq_pkg::S_SHIFT: begin
				wr_addr_q <= sh_rd_q - IW'(1);
				sh_rd_q   <= sh_rd_q + IW'(1);
			end
			default: begin
				wr_addr_q <= wr_addr_q;
			end
		endcase
	end

	assign busy         = (state_q != umpq_pkg::S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_value    = value_q;
	assign out_priority = priority_q;
	assign out_position = position_q;
	assign occupancy    = occupancy_q;

	// A result only appears once the sequencer is back in idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == umpq_pkg::S_IDLE))
		else $error("result shown while sequencer busy");

	// The fill count never exceeds the memory depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(umpq_pkg::DEPTH))
		else $error("fill count beyond depth");

	// The sequencer only leaves idle because of a command transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// The shift never reads past the last stored entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == umpq_pkg::S_SHIFT) |-> (CW'(sh_rd_q) < count_q))
		else $error("shift read beyond stored entries");

	// An empty report always comes with an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == umpq_pkg::ST_EMPTY)) |-> (occupancy == 8'd0))
		else $error("empty status with stored entries");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the unordered max priority queue: directed and random commands,
// checked against a cycle-free predictor kept in a small scoreboard class.
// Depends on umpq_pkg and unordered_max_priority_queue.

module tb_top;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 850;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic signed [31:0] prio;
		logic [6:0]         position;
		logic [7:0]         occupancy;
	} queue_result_t;

	class queue_scoreboard;
		logic signed [31:0] vals [umpq_pkg::DEPTH];
		logic signed [31:0] prios [umpq_pkg::DEPTH];
		int count = 0;
		int errors = 0;
		queue_result_t expected [$];

		function int pending();
			return expected.size();
		endfunction

		task report(input string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		// Applies one accepted command transfer to the shadow queue.
		function void note_command(input logic [1:0] code, input logic signed [31:0] v,
				input logic signed [31:0] p);
			queue_result_t r;
			int best;
			int i;
			r.status = umpq_pkg::ST_OK;
			r.value = '0;
			r.prio = '0;
			r.position = '0;
			case (code)
				umpq_pkg::OP_ENQ: begin
					if (count >= umpq_pkg::DEPTH) begin
						r.status = umpq_pkg::ST_FULL;
					end else begin
						vals[count] = v;
						prios[count] = p;
						count++;
					end
				end
				umpq_pkg::OP_DEQ, umpq_pkg::OP_PEEK: begin
					if (count == 0) begin
						r.status = umpq_pkg::ST_EMPTY;
					end else begin
						// Entry 0 seeds the search; strict compares keep the earliest on a full tie.
						best = 0;
						for (i = 1; i < count; i++) begin
							if (prios[i] > prios[best] ||
									(prios[i] == prios[best] && vals[i] > vals[best]))
								best = i;
						end
						r.value = vals[best];
						r.prio = prios[best];
						r.position = 7'(best);
						if (code == umpq_pkg::OP_DEQ) begin
							for (i = best; i < count - 1; i++) begin
								vals[i] = vals[i + 1];
								prios[i] = prios[i + 1];
							end
							count--;
						end
					end
				end
				default: ;
			endcase
			r.occupancy = 8'(count);
			expected.push_back(r);
		endfunction

		task check_result(input logic [1:0] st, input logic signed [31:0] v,
				input logic signed [31:0] p, input logic [6:0] pos, input logic [7:0] occ);
			queue_result_t e;
			if (expected.size() == 0) begin
				report($sformatf("result with nothing outstanding, status %0d", st));
				return;
			end
			e = expected.pop_front();
			if (st !== e.status)
				report($sformatf("status %0d, predicted %0d", st, e.status));
			if (v !== e.value)
				report($sformatf("out_value %0d, predicted %0d", v, e.value));
			if (p !== e.prio)
				report($sformatf("out_priority %0d, predicted %0d", p, e.prio));
			if (pos !== e.position)
				report($sformatf("out_position %0d, predicted %0d", pos, e.position));
			if (occ !== e.occupancy)
				report($sformatf("occupancy %0d, predicted %0d", occ, e.occupancy));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         op = umpq_pkg::OP_ENQ;
	logic signed [31:0] item_value = '0;
	logic signed [31:0] item_priority = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_priority;
	logic [6:0]         out_position;
	logic [7:0]         occupancy;

	queue_scoreboard sb;
	int unsigned cycles = 0;

	unordered_max_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.item_value    (item_value),
		.item_priority (item_priority),
		.done          (done),
		.status        (status),
		.out_value     (out_value),
		.out_priority  (out_priority),
		.out_position  (out_position),
		.occupancy     (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, out_value, out_priority, out_position, occupancy);
	end

	// Holds start high until the transfer happens, then records it.
	task automatic send(input logic [1:0] code, input logic signed [31:0] v,
			input logic signed [31:0] p);
		start <= 1'b1;
		op <= code;
		item_value <= v;
		item_priority <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(code, v, p);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Small values and extremes are favored so that priority and value ties occur.
	function automatic logic signed [31:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 32'(int'($urandom_range(0, 6)) - 3);
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		logic [1:0] code;
		int unsigned r;
		int burst_left;
		int gap;
		int overshoot;
		bit filling;

		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, lowest priorities, full ties, then highest priorities.
		send(umpq_pkg::OP_PEEK, 32'sd7, 32'sd7);
		send(umpq_pkg::OP_DEQ, -32'sd1, -32'sd1);
		send(OP_NONE, 32'sh7fff_ffff, 32'sh8000_0000);
		send(umpq_pkg::OP_ENQ, 32'sh8000_0000, 32'sh8000_0000);
		send(umpq_pkg::OP_ENQ, 32'sh7fff_ffff, 32'sh8000_0000);
		send(umpq_pkg::OP_ENQ, 32'sh7fff_ffff, 32'sh8000_0000);
		send(umpq_pkg::OP_PEEK, 32'sd0, 32'sd0);
		send(OP_NONE, $urandom, $urandom);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_ENQ, -32'sd1, 32'sh7fff_ffff);
		send(umpq_pkg::OP_ENQ, 32'sd0, 32'sh7fff_ffff);
		send(umpq_pkg::OP_ENQ, 32'sd5, -32'sd1);
		send(umpq_pkg::OP_PEEK, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		send(umpq_pkg::OP_DEQ, 32'sd0, 32'sd0);
		wait_drained();

		// Alternate between filling past full and draining past empty.
		burst_left = 0;
		overshoot = 0;
		filling = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n > 0 && n % 250 == 0)
				wait_drained();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300)
						: $urandom_range(0, 12);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (filling)
				code = (r < 80) ? umpq_pkg::OP_ENQ : (r < 90) ? umpq_pkg::OP_DEQ :
						(r < 97) ? umpq_pkg::OP_PEEK : OP_NONE;
			else
				code = (r < 10) ? umpq_pkg::OP_ENQ : (r < 82) ? umpq_pkg::OP_DEQ :
						(r < 95) ? umpq_pkg::OP_PEEK : OP_NONE;
			send(code, pick_word(), pick_word());
			if (filling ? (sb.count == umpq_pkg::DEPTH) : (sb.count == 0)) begin
				overshoot++;
				if (overshoot > 10) begin
					overshoot = 0;
					filling = !filling;
				end
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/umpq_pkg.sv
hdl/umpq_store.sv
hdl/umpq_cmp.sv
hdl/unordered_max_priority_queue.sv
sim/tb_top.sv
